// ===== rtl/rgbw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbw_pkg
// Types and constants shared by the RGBW LED port controller.
// ----------------------------------------------------------------------------
package rgbw_pkg;

  localparam int MAX_PORTS = 3;

  localparam int CMD_W    = 2;
  localparam int PORT_W   = 3;
  localparam int RGB_W    = 24;
  localparam int STATUS_W = 2;
  localparam int PWM_W    = 32;
  localparam int LEVEL_W  = 8;
  localparam int TIMER_W  = 24;
  localparam int ELAPSED_W = 14;
  localparam int PHASE_W  = 3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_OTHER = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LOCKED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_LOCK    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WHITE   = 2'd2;

  // Test sequence phases.
  localparam logic [PHASE_W-1:0] PH_OFF   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_RED   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_GREEN = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BLUE  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_WHITE = 3'd4;

  localparam logic [RGB_W-1:0]     FULL_RGB      = 24'hFFFFFF;
  localparam logic [TIMER_W-1:0]   TIMER_MAX     = 24'hFFFFFF;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 14'h3FFF;
  localparam logic [TIMER_W-1:0]   TIMEOUT_RESET = 24'd10000;
  localparam logic [LEVEL_W-1:0]   WHITE_RESET   = 8'hFF;
  localparam logic [LEVEL_W-1:0]   LEVEL_FULL    = 8'hFF;

  localparam logic [ELAPSED_W-1:0] T_RED   = 14'd2000;
  localparam logic [ELAPSED_W-1:0] T_GREEN = 14'd4000;
  localparam logic [ELAPSED_W-1:0] T_BLUE  = 14'd6000;
  localparam logic [ELAPSED_W-1:0] T_WHITE = 14'd8000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PORT_W-1:0] port;
    logic [RGB_W-1:0]  rgb;
  } item_t;

  typedef struct packed {
    logic                 locked;
    logic [TIMER_W-1:0]   timeout_ms;
    logic [LEVEL_W-1:0]   white_level;
  } cfg_t;

  typedef struct packed {
    logic [MAX_PORTS-1:0][PWM_W-1:0] pwm;
    logic [MAX_PORTS-1:0][RGB_W-1:0] colour;
    logic [MAX_PORTS-1:0]            ports_on;
    logic                            test_running;
  } view_t;

endpackage

// ===== rtl/rgbw_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbw_req_if
// Command channel: one item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface rgbw_req_if import rgbw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [PORT_W-1:0] port;
  logic [RGB_W-1:0]  rgb;

  modport source (output valid, output cmd, output port, output rgb, input ready);
  modport sink (input valid, input cmd, input port, input rgb, output ready);
endinterface

// ===== rtl/rgbw_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbw_rsp_if
// Result channel: status and the port levels after each item.
// ----------------------------------------------------------------------------
interface rgbw_rsp_if import rgbw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PWM_W-1:0]    port1_pwm;
  logic [PWM_W-1:0]    port2_pwm;
  logic [PWM_W-1:0]    port3_pwm;
  logic [RGB_W-1:0]    port1_colour;
  logic [RGB_W-1:0]    port2_colour;
  logic [RGB_W-1:0]    port3_colour;
  logic [2:0]          ports_on;
  logic                test_running;

  modport source (
    output valid, output status,
    output port1_pwm, output port2_pwm, output port3_pwm,
    output port1_colour, output port2_colour, output port3_colour,
    output ports_on, output test_running,
    input ready
  );
  modport sink (
    input valid, input status,
    input port1_pwm, input port2_pwm, input port3_pwm,
    input port1_colour, input port2_colour, input port3_colour,
    input ports_on, input test_running,
    output ready
  );
endinterface

// ===== rtl/rgbw_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbw_state
// Port levels, colours, timeout counter and test sequencer. Applies one item
// per step and exposes the resulting state.
// ----------------------------------------------------------------------------
module rgbw_state import rgbw_pkg::*; #(
  parameter int PORTS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  item_t               item,
  input  cfg_t                cfg,
  output logic [STATUS_W-1:0] status_next,
  output view_t               view
);

  logic [PORTS-1:0][PWM_W-1:0] levels, levels_next;
  logic [PORTS-1:0][RGB_W-1:0] colour, colour_next;
  logic [PORTS-1:0]            on_bits, on_bits_next;
  logic [TIMER_W-1:0]          since, since_next;
  logic                        test_active, test_active_next;
  logic [PHASE_W-1:0]          phase, phase_next;
  logic [ELAPSED_W-1:0]        elapsed, elapsed_next;

  logic [TIMER_W-1:0]   since_inc;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [PWM_W-1:0]     set_levels;
  logic                 port_bad;

  assign since_inc   = (since != TIMER_MAX) ? since + 1'b1 : since;
  assign elapsed_inc = (elapsed != ELAPSED_MAX) ? elapsed + 1'b1 : elapsed;
  // Pure white lights the white channel alone.
  assign set_levels  = (item.rgb == FULL_RGB) ? {24'h0, cfg.white_level} : {item.rgb, 8'h0};
  assign port_bad    = (item.port == '0) || (item.port > PORT_W'(PORTS));

  always_comb begin
    levels_next      = levels;
    colour_next      = colour;
    on_bits_next     = on_bits;
    since_next       = since;
    test_active_next = test_active;
    phase_next       = phase;
    elapsed_next     = elapsed;
    status_next      = STATUS_OK;

    if (cfg.locked) begin
      status_next = STATUS_LOCKED;
    end else begin
      unique case (item.cmd)
        CMD_TICK: begin
          since_next = since_inc;
          if (since_inc >= cfg.timeout_ms) begin
            levels_next  = '0;
            colour_next  = '0;
            on_bits_next = '0;
          end
          if (test_active) begin
            if (phase == PH_OFF) begin
              elapsed_next = '0;
              phase_next   = PH_RED;
              for (int i = 0; i < PORTS; i++) levels_next[i] = {LEVEL_FULL, 24'h0};
            end else if (phase > PH_WHITE) begin
              phase_next       = PH_OFF;
              test_active_next = 1'b0;
            end else begin
              elapsed_next = elapsed_inc;
              if (phase == PH_RED && elapsed_inc > T_RED) begin
                phase_next = PH_GREEN;
                for (int i = 0; i < PORTS; i++) levels_next[i] = {8'h0, LEVEL_FULL, 16'h0};
              end else if (phase == PH_GREEN && elapsed_inc > T_GREEN) begin
                phase_next = PH_BLUE;
                for (int i = 0; i < PORTS; i++) levels_next[i] = {16'h0, LEVEL_FULL, 8'h0};
              end else if (phase == PH_BLUE && elapsed_inc > T_BLUE) begin
                phase_next = PH_WHITE;
                for (int i = 0; i < PORTS; i++) levels_next[i] = {24'h0, cfg.white_level};
              end else if (phase == PH_WHITE && elapsed_inc > T_WHITE) begin
                phase_next       = PH_OFF;
                test_active_next = 1'b0;
                levels_next      = '0;
              end
            end
          end
        end
        CMD_SET: begin
          phase_next       = PH_OFF;
          test_active_next = 1'b0;
          if (port_bad) begin
            status_next = STATUS_REJECT;
          end else begin
            if (item.rgb != '0) since_next = '0;
            for (int i = 0; i < PORTS; i++) begin
              if (item.port == PORT_W'(i + 1)) begin
                levels_next[i]  = set_levels;
                colour_next[i]  = item.rgb;
                on_bits_next[i] = (item.rgb != '0);
              end
            end
          end
        end
        CMD_TEST: begin
          // Starting the test also switches port 1 off.
          test_active_next = 1'b1;
          levels_next[0]   = '0;
          colour_next[0]   = '0;
          on_bits_next[0]  = 1'b0;
        end
        CMD_OTHER: begin
          phase_next       = PH_OFF;
          test_active_next = 1'b0;
          status_next      = STATUS_REJECT;
        end
        default: begin
          status_next = STATUS_REJECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels      <= '0;
      colour      <= '0;
      on_bits     <= '0;
      since       <= '0;
      test_active <= 1'b0;
      phase       <= PH_OFF;
      elapsed     <= '0;
    end else if (step) begin
      levels      <= levels_next;
      colour      <= colour_next;
      on_bits     <= on_bits_next;
      since       <= since_next;
      test_active <= test_active_next;
      phase       <= phase_next;
      elapsed     <= elapsed_next;
    end
  end

  // Ports beyond PORTS read as zero.
  for (genvar g = 0; g < MAX_PORTS; g++) begin : g_view
    if (g < PORTS) begin : g_used
      assign view.pwm[g]      = levels[g];
      assign view.colour[g]   = colour[g];
      assign view.ports_on[g] = on_bits[g];
    end else begin : g_unused
      assign view.pwm[g]      = '0;
      assign view.colour[g]   = '0;
      assign view.ports_on[g] = 1'b0;
    end
  end
  assign view.test_running = test_active;

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(since) && $stable(levels) && $stable(phase))
    else $error("state changed without a step");

  a_locked_freezes: assert property (@(posedge clk) disable iff (rst)
    step && cfg.locked |=> $stable(colour) && $stable(on_bits) && $stable(test_active))
    else $error("locked item changed state");

  a_set_stops_test: assert property (@(posedge clk) disable iff (rst)
    step && !cfg.locked && item.cmd == CMD_SET |=> !test_active && phase == PH_OFF)
    else $error("set colour left the test running");

endmodule

// ===== rtl/rgbw_led_port_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbw_led_port_controller
// RGBW PWM level holder for up to three LED ports with timeout and test.
// ----------------------------------------------------------------------------
// Takes one item per clock while results are taken and returns one result per
// item. An item is captured in an input register, then applied to the port
// state as its status enters the result register, and its result is presented
// from there. While a result waits, the input register can still take one item
// and then holds it until the result is read. The result carries the state
// left by its item. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must do so only while the block is idle, as the block
// itself does not enforce it.
module rgbw_led_port_controller import rgbw_pkg::*; #(
  parameter int PORTS = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  rgbw_req_if.sink               req,
  rgbw_rsp_if.source             rsp
);

  cfg_t                cfg;
  item_t               stage_item;
  logic                stage_valid;
  logic                rsp_valid;
  logic [STATUS_W-1:0] status;
  logic [STATUS_W-1:0] status_next;
  logic                advance;
  view_t               view;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.locked      <= 1'b0;
      cfg.timeout_ms  <= TIMEOUT_RESET;
      cfg.white_level <= WHITE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCK:    cfg.locked      <= cfg_data[0];
        REG_TIMEOUT: cfg.timeout_ms  <= cfg_data[TIMER_W-1:0];
        REG_WHITE:   cfg.white_level <= cfg_data[LEVEL_W-1:0];
        default:     ;
      endcase
    end
  end

  // The staged item moves on whenever the result slot is free or being read.
  assign advance   = stage_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_item <= '{cmd: req.cmd, port: req.port, rgb: req.rgb};
    end
    if (advance) begin
      status <= status_next;
    end
  end

  rgbw_state #(
    .PORTS(PORTS)
  ) u_state (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (stage_item),
    .cfg         (cfg),
    .status_next (status_next),
    .view        (view)
  );

  // State changes only when the result slot turns over, so the state
  // registers serve directly as the result payload.
  assign rsp.valid        = rsp_valid;
  assign rsp.status       = status;
  assign rsp.port1_pwm    = view.pwm[0];
  assign rsp.port2_pwm    = view.pwm[1];
  assign rsp.port3_pwm    = view.pwm[2];
  assign rsp.port1_colour = view.colour[0];
  assign rsp.port2_colour = view.colour[1];
  assign rsp.port3_colour = view.colour[2];
  assign rsp.ports_on     = view.ports_on;
  assign rsp.test_running = view.test_running;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && stage_valid |-> advance)
    else $error("staged item overwritten");

  a_stage_kept: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_item))
    else $error("staged item lost");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("advanced item produced no result");

endmodule

// ===== tb/tb_rgbw_led_port_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgbw_led_port_controller
// Self-checking bench for the RGBW LED port controller. A queue of commands
// and ticks feeds a handshake driver; every accepted item runs through a
// behavioral copy of the port state, and the monitor compares each result
// field by field. Phases under several register settings cover the lock,
// short and zero timeouts, the white level and the start of the test sequence.
// ----------------------------------------------------------------------------
module tb_rgbw_led_port_controller;
  import rgbw_pkg::*;

  localparam int PORTS       = 3;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    view_t               view;
  } led_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_LOCK;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  rgbw_req_if cmd_bus ();
  rgbw_rsp_if res_bus ();

  rgbw_led_port_controller #(.PORTS(PORTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (cmd_bus),
    .rsp       (res_bus)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Behavioral copy of the controller, starting from its reset state.
  logic                            led_locked  = 1'b0;
  logic [TIMER_W-1:0]              led_timeout = TIMEOUT_RESET;
  logic [LEVEL_W-1:0]              led_white   = WHITE_RESET;
  logic [MAX_PORTS-1:0][PWM_W-1:0] led_pwm     = '0;
  logic [MAX_PORTS-1:0][RGB_W-1:0] led_colour  = '0;
  logic [MAX_PORTS-1:0]            led_on      = '0;
  logic [TIMER_W-1:0]              idle_ms     = '0;
  logic                            test_on     = 1'b0;
  logic [PHASE_W-1:0]              test_phase  = PH_OFF;
  logic [ELAPSED_W-1:0]            test_ms     = '0;

  item_t       pending[$];
  led_result_t results_due[$];

  logic no_idle = 1'b0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   items_taken = 0;
  int   locked_items = 0;
  int   timeout_clears = 0;
  int   tests_done = 0;
  int   cmd_count[4] = '{0, 0, 0, 0};
  int   stall_cycles = 0;

  function automatic void paint_port(input int p, input logic [RGB_W-1:0] rgb);
    if (rgb == FULL_RGB)
      led_pwm[p] = {24'h0, led_white};
    else
      led_pwm[p] = {rgb, 8'h00};
    led_on[p]     = (rgb != '0);
    led_colour[p] = rgb;
  endfunction

  function automatic void show_on_all(input logic [PWM_W-1:0] levels);
    for (int i = 0; i < PORTS; i++)
      led_pwm[i] = levels;
  endfunction

  function automatic void stop_test();
    test_phase = PH_OFF;
    test_on    = 1'b0;
  endfunction

  // Updates the port state for one accepted item and returns its result.
  function automatic led_result_t apply_led_item(input item_t it);
    led_result_t r;
    r.status = STATUS_OK;
    if (led_locked) begin
      r.status = STATUS_LOCKED;
      locked_items++;
    end else begin
      cmd_count[it.cmd]++;
      case (it.cmd)
        CMD_TICK: begin
          if (idle_ms != TIMER_MAX)
            idle_ms = idle_ms + 1'b1;
          if (idle_ms >= led_timeout) begin
            led_pwm    = '0;
            led_colour = '0;
            led_on     = '0;
            timeout_clears++;
          end
          if (test_on) begin
            if (test_phase == PH_OFF) begin
              test_ms    = '0;
              test_phase = PH_RED;
              show_on_all({LEVEL_FULL, 24'h0});
            end else if (test_phase > PH_WHITE) begin
              stop_test();
            end else begin
              if (test_ms != ELAPSED_MAX)
                test_ms = test_ms + 1'b1;
              if (test_phase == PH_RED && test_ms > T_RED) begin
                test_phase = PH_GREEN;
                show_on_all({8'h0, LEVEL_FULL, 16'h0});
              end else if (test_phase == PH_GREEN && test_ms > T_GREEN) begin
                test_phase = PH_BLUE;
                show_on_all({16'h0, LEVEL_FULL, 8'h0});
              end else if (test_phase == PH_BLUE && test_ms > T_BLUE) begin
                test_phase = PH_WHITE;
                show_on_all({24'h0, led_white});
              end else if (test_phase == PH_WHITE && test_ms > T_WHITE) begin
                stop_test();
                show_on_all('0);
                tests_done++;
              end
            end
          end
        end
        CMD_TEST: begin
          // Starting the test also switches port 1 off, leaving the timer alone.
          test_on = 1'b1;
          paint_port(0, '0);
        end
        CMD_SET: begin
          stop_test();
          if (it.port < 1 || it.port > PORTS) begin
            r.status = STATUS_REJECT;
          end else begin
            if (it.rgb != '0)
              idle_ms = '0;
            paint_port(int'(it.port) - 1, it.rgb);
          end
        end
        default: begin
          stop_test();
          r.status = STATUS_REJECT;
        end
      endcase
    end
    r.view.pwm          = led_pwm;
    r.view.colour       = led_colour;
    r.view.ports_on     = led_on;
    r.view.test_running = test_on;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (seen !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in result %0d, %s: expected %h, got %h",
                 results_seen, name, want, seen);
    end
  endfunction

  // Driver: presents queued items and predicts each one as it is taken.
  always @(posedge clk) begin
    item_t took;
    item_t nxt;
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        took.cmd  = cmd_bus.cmd;
        took.port = cmd_bus.port;
        took.rgb  = cmd_bus.rgb;
        results_due.push_back(apply_led_item(took));
        items_taken++;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (pending.size() != 0 && (no_idle || $urandom_range(99) >= 11)) begin
          nxt = pending.pop_front();
          cmd_bus.valid <= 1'b1;
          cmd_bus.cmd   <= nxt.cmd;
          cmd_bus.port  <= nxt.port;
          cmd_bus.rgb   <= nxt.rgb;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest prediction.
  always @(posedge clk) begin
    led_result_t want;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with no item waiting for it", results_seen);
        end else begin
          want = results_due.pop_front();
          check_field("status", 32'(want.status), 32'(res_bus.status));
          check_field("port1_pwm", want.view.pwm[0], res_bus.port1_pwm);
          check_field("port2_pwm", want.view.pwm[1], res_bus.port2_pwm);
          check_field("port3_pwm", want.view.pwm[2], res_bus.port3_pwm);
          check_field("port1_colour", 32'(want.view.colour[0]), 32'(res_bus.port1_colour));
          check_field("port2_colour", 32'(want.view.colour[1]), 32'(res_bus.port2_colour));
          check_field("port3_colour", 32'(want.view.colour[2]), 32'(res_bus.port3_colour));
          check_field("ports_on", 32'(want.view.ports_on), 32'(res_bus.ports_on));
          check_field("test_running", 32'(want.view.test_running),
                      32'(res_bus.test_running));
        end
      end
      res_bus.ready <= no_idle || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", stall_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [PORT_W-1:0] port,
                          input logic [RGB_W-1:0] rgb);
    item_t it;
    it.cmd  = cmd;
    it.port = port;
    it.rgb  = rgb;
    pending.push_back(it);
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++)
      push_cmd(CMD_TICK, PORT_W'($urandom()), RGB_W'($urandom()));
  endtask

  // Random mix; tick_pct sets how often the item is a millisecond tick.
  task automatic queue_random(input int n, input int tick_pct);
    logic [CMD_W-1:0]  cmd;
    logic [PORT_W-1:0] port;
    logic [RGB_W-1:0]  rgb;
    int                pick;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < tick_pct) begin
        cmd = CMD_TICK;
      end else begin
        pick = $urandom_range(9);
        cmd  = (pick < 7) ? CMD_SET : (pick < 9) ? CMD_TEST : CMD_OTHER;
      end
      port = ($urandom_range(9) < 8) ? PORT_W'($urandom_range(1, PORTS))
                                     : PORT_W'($urandom());
      case ($urandom_range(7))
        0:       rgb = '0;
        1:       rgb = FULL_RGB;
        2:       rgb = FULL_RGB - 1'b1;
        3:       rgb = RGB_W'(1) << $urandom_range(RGB_W - 1);
        default: rgb = RGB_W'($urandom());
      endcase
      push_cmd(cmd, port, rgb);
    end
  endtask

  // Waits until every queued item is sent and every result is in, then lets the block settle.
  task automatic drain();
    while (pending.size() != 0 || cmd_bus.valid || results_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LOCK:    led_locked  = data[0];
      REG_TIMEOUT: led_timeout = data[TIMER_W-1:0];
      REG_WHITE:   led_white   = data[LEVEL_W-1:0];
      default:     ;
    endcase
  endtask

  initial begin
    rst           = 1'b1;
    cmd_bus.valid = 1'b0;
    cmd_bus.cmd   = CMD_TICK;
    cmd_bus.port  = '0;
    cmd_bus.rgb   = '0;
    res_bus.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings.
    push_cmd(CMD_SET, 3'd1, FULL_RGB);
    push_cmd(CMD_SET, 3'd2, 24'h123456);
    push_cmd(CMD_SET, 3'd3, 24'h000001);
    push_cmd(CMD_SET, 3'd0, 24'h112233);
    push_cmd(CMD_SET, 3'd4, 24'hABCDEF);
    push_cmd(CMD_SET, 3'd7, FULL_RGB);
    push_cmd(CMD_SET, 3'd2, 24'h000000);
    push_cmd(CMD_SET, 3'd3, 24'hFFFFFE);
    push_cmd(CMD_SET, 3'd1, 24'hFF0000);
    push_cmd(CMD_OTHER, 3'd5, 24'h5A5A5A);
    push_ticks(3);
    push_cmd(CMD_TEST, 3'd6, FULL_RGB);
    push_ticks(3);
    push_cmd(CMD_TEST, 3'd0, 24'h000000);
    push_ticks(1);
    push_cmd(CMD_SET, 3'd3, 24'h00FF00);
    push_cmd(CMD_TEST, 3'd2, 24'h000000);
    push_cmd(CMD_OTHER, 3'd7, FULL_RGB);
    push_ticks(2);
    drain();

    // Locked: every command is refused and the timer does not age.
    write_reg(REG_LOCK, 24'd1);
    push_cmd(CMD_TICK, 3'd1, 24'h0);
    push_cmd(CMD_SET, 3'd2, FULL_RGB);
    push_cmd(CMD_TEST, 3'd3, 24'h1);
    push_cmd(CMD_OTHER, 3'd0, 24'h7);
    queue_random(8, 40);
    drain();

    write_reg(REG_LOCK, 24'd0);
    write_reg(REG_TIMEOUT, 24'd1);
    write_reg(REG_WHITE, 24'd0);
    queue_random(150, 40);
    drain();

    // A stretch with both sides always ready.
    no_idle = 1'b1;
    write_reg(REG_TIMEOUT, 24'd6);
    write_reg(REG_WHITE, 24'h80);
    queue_random(200, 60);
    drain();
    no_idle = 1'b0;

    write_reg(REG_TIMEOUT, 24'd0);
    queue_random(100, 45);
    drain();

    // Test sequence with the timeout far away; a restart mid-way keeps the phase.
    write_reg(REG_TIMEOUT, TIMER_MAX);
    write_reg(REG_WHITE, 24'h5A);
    push_cmd(CMD_SET, 3'd2, 24'h010203);
    push_cmd(CMD_TEST, 3'd1, 24'h0);
    push_ticks(150);
    drain();
    push_cmd(CMD_TEST, 3'd3, FULL_RGB);
    push_ticks(100);
    queue_random(20, 50);
    drain();

    write_reg(REG_TIMEOUT, 24'd15);
    write_reg(REG_WHITE, 24'hFF);
    queue_random(200, 85);
    drain();

    write_reg(REG_LOCK, 24'd1);
    queue_random(10, 40);
    drain();
    write_reg(REG_LOCK, 24'd0);
    write_reg(REG_TIMEOUT, 24'd3);
    queue_random(150, 50);
    drain();

    $display("covered %0d items: %0d ticks, %0d sets, %0d test starts, %0d other, %0d locked",
             items_taken, cmd_count[CMD_TICK], cmd_count[CMD_SET], cmd_count[CMD_TEST],
             cmd_count[CMD_OTHER], locked_items);
    $display("%0d results checked, %0d timeout clears, %0d complete test runs, %0d mismatches",
             results_seen, timeout_clears, tests_done, mismatches);
    if (mismatches == 0 && results_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
